// ===== rtl/umnf_pkg.sv =====
// ----------------------------------------------------------------------------
// umnf_pkg
// Types and constants shared by the missing-node fill block: the input and
// result transaction structs and the classification carried between the
// front and back parts.
// ----------------------------------------------------------------------------
package umnf_pkg;

	localparam int NODE_BITS     = 24;
	localparam int REF_BITS      = 13;
	localparam int MAX_EDGES_DEF = 4096;
	localparam int QUEUE_DEPTH   = 4;

	typedef logic [NODE_BITS-1:0] node_t;
	typedef logic [REF_BITS-1:0]  ref_t;

	typedef struct packed {
		logic  restart;
		node_t first_node;
		node_t second_node;
		ref_t  first_ref;
		ref_t  second_ref;
		logic  first_coin;
		logic  second_coin;
	} in_t;

	typedef struct packed {
		node_t filled_first;
		node_t filled_second;
		logic  ref_error;
	} out_t;

	typedef enum logic [1:0] {
		F_NODE,
		F_MEM,
		F_ZERO
	} first_src_t;

	typedef enum logic [1:0] {
		S_NODE,
		S_MEM,
		S_CUR,
		S_ZERO
	} second_src_t;

	typedef struct packed {
		first_src_t  src1;
		second_src_t src2;
		logic        coin1;
		logic        coin2;
		logic        write_en;
		logic        err;
		node_t       node1;
		node_t       node2;
	} class_t;

endpackage

// ===== rtl/undirected_missing_node_fill.sv =====
// ----------------------------------------------------------------------------
// undirected_missing_node_fill
// Fills missing end nodes of a stream of undirected edges by copying ends of
// earlier edges held in an on-chip edge store.
// ----------------------------------------------------------------------------
// The block takes one edge per clock cycle while edge_stall is low and
// returns one result per edge, in order: the front stage classifies the
// edge into a four-entry queue, the back stage reads the edge store at both
// references into its stage registers and resolves the ends into the output
// register. The throughput of one edge per cycle is set by the edge store,
// which can take one write and two reads at once; the most recent write is
// forwarded so that an edge may copy from the one just before it. The store
// needs no clearing after reset, as only entries written in the current
// sequence can be referenced.
module undirected_missing_node_fill import umnf_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic edge_valid,
	output logic edge_stall,
	input  in_t  edge_item,
	output logic result_valid,
	input  logic result_stall,
	output out_t result_item
);

	localparam int AW = $clog2(MAX_EDGES);
	localparam int CLW = $bits(class_t);
	localparam int QW = CLW + 3 * AW;

	logic          accept;
	class_t        f_cls;
	logic [AW-1:0] f_addr1;
	logic [AW-1:0] f_addr2;
	logic [AW-1:0] f_waddr;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	logic          q_nonempty;
	logic          q_pop;
	class_t        q_cls;

	assign accept = edge_valid && !edge_stall;
	assign q_din  = {f_cls, f_addr1, f_addr2, f_waddr};
	assign q_cls  = class_t'(q_dout[QW-1:3*AW]);

	umnf_front #(.MAX_EDGES(MAX_EDGES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (edge_item),
		.accept (accept),
		.cls    (f_cls),
		.addr1  (f_addr1),
		.addr2  (f_addr2),
		.waddr  (f_waddr)
	);

	umnf_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.din      (q_din),
		.full     (edge_stall),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.dout     (q_dout)
	);

	umnf_back #(.MAX_EDGES(MAX_EDGES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_cls        (q_cls),
		.q_addr1      (q_dout[3*AW-1:2*AW]),
		.q_addr2      (q_dout[2*AW-1:AW]),
		.q_waddr      (q_dout[AW-1:0]),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

// ===== rtl/umnf_front.sv =====
// ----------------------------------------------------------------------------
// umnf_front
// Keeps the edge position of the current sequence and classifies each
// incoming edge: where each end comes from, which store entries to read,
// where the edge is written and whether an error is reported.
// ----------------------------------------------------------------------------
module umnf_front import umnf_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int AW = $clog2(MAX_EDGES),
	localparam int PW = $clog2(MAX_EDGES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_t           item,
	input  logic          accept,
	output class_t        cls,
	output logic [AW-1:0] addr1,
	output logic [AW-1:0] addr2,
	output logic [AW-1:0] waddr
);

	localparam int CW = (PW > REF_BITS) ? PW : REF_BITS;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] r1_w;
	logic [CW-1:0] r2_w;
	logic [CW-1:0] r1_m1;
	logic [CW-1:0] r2_m1;
	logic          cap;
	logic          ok1;
	logic          ok2;
	logic          cur2;
	logic          err1;
	logic          err2;

	always_comb begin
		pos   = item.restart ? '0 : pos_q;
		pos_w = CW'(pos);
		r1_w  = CW'(item.first_ref);
		r2_w  = CW'(item.second_ref);
		r1_m1 = r1_w - CW'(1);
		r2_m1 = r2_w - CW'(1);
		cap   = (pos == PW'(MAX_EDGES));
		ok1   = (r1_w != '0) && (r1_w <= pos_w);
		ok2   = (r2_w != '0) && (r2_w <= pos_w);
		cur2  = (r2_w == pos_w + CW'(1));
		addr1 = r1_m1[AW-1:0];
		addr2 = r2_m1[AW-1:0];
		waddr = pos[AW-1:0];

		cls.coin1    = item.first_coin;
		cls.coin2    = item.second_coin;
		cls.node1    = item.first_node;
		cls.node2    = item.second_node;
		cls.write_en = !cap;
		err1         = 1'b0;
		err2         = 1'b0;

		priority if (item.first_node != '0) begin
			cls.src1 = F_NODE;
		end else if (ok1) begin
			cls.src1 = F_MEM;
		end else begin
			cls.src1 = F_ZERO;
			err1     = 1'b1;
		end

		priority if (item.second_node != '0) begin
			cls.src2 = S_NODE;
		end else if (ok2) begin
			cls.src2 = S_MEM;
		end else if (cur2) begin
			cls.src2 = item.second_coin ? S_ZERO : S_CUR;
		end else begin
			cls.src2 = S_ZERO;
			err2     = 1'b1;
		end

		cls.err = err1 | err2;
		if (cap) begin
			cls.src1 = F_ZERO;
			cls.src2 = S_ZERO;
			cls.err  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= cap ? pos : pos + PW'(1);
		end
	end

endmodule

// ===== rtl/umnf_queue.sv =====
// ----------------------------------------------------------------------------
// umnf_queue
// Short first-in first-out queue holding classified edges between the front
// and back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module umnf_queue import umnf_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] dout
);

	logic [W-1:0]    entry_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign dout     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== rtl/umnf_back.sv =====
// ----------------------------------------------------------------------------
// umnf_back
// Reads the edge store for each classified edge, resolves both ends with
// forwarding of the most recent write, writes the resolved edge back and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module umnf_back import umnf_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int AW = $clog2(MAX_EDGES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  class_t        q_cls,
	input  logic [AW-1:0] q_addr1,
	input  logic [AW-1:0] q_addr2,
	input  logic [AW-1:0] q_waddr,
	output logic          q_pop,
	output logic          result_valid,
	input  logic          result_stall,
	output out_t          result_item
);

	localparam int EW = 2 * NODE_BITS;

	logic [EW-1:0] store [MAX_EDGES];

	logic          valid_s2;
	class_t        cls_s2;
	logic [AW-1:0] a1_s2;
	logic [AW-1:0] a2_s2;
	logic [AW-1:0] wa_s2;
	logic [EW-1:0] rd1_s2;
	logic [EW-1:0] rd2_s2;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [EW-1:0] fwd_data_q;

	logic          adv;
	logic [EW-1:0] e1;
	logic [EW-1:0] e2;
	node_t         v1;
	node_t         v2;
	node_t         f1;
	node_t         f2;

	assign adv   = valid_s2 && (!result_valid || !result_stall);
	assign q_pop = q_nonempty && (!valid_s2 || adv);

	always_comb begin
		e1 = (fwd_valid_q && fwd_addr_q == a1_s2) ? fwd_data_q : rd1_s2;
		e2 = (fwd_valid_q && fwd_addr_q == a2_s2) ? fwd_data_q : rd2_s2;
		v1 = cls_s2.coin1 ? e1[NODE_BITS-1:0] : e1[EW-1:NODE_BITS];
		v2 = cls_s2.coin2 ? e2[NODE_BITS-1:0] : e2[EW-1:NODE_BITS];

		unique case (cls_s2.src1)
			F_NODE:  f1 = cls_s2.node1;
			F_MEM:   f1 = v1;
			F_ZERO:  f1 = '0;
			default: f1 = '0;
		endcase

		unique case (cls_s2.src2)
			S_NODE: f2 = cls_s2.node2;
			S_MEM:  f2 = v2;
			S_CUR:  f2 = f1;
			S_ZERO: f2 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && cls_s2.write_en) begin
			store[wa_s2] <= {f1, f2};
		end
		if (q_pop) begin
			rd1_s2 <= store[q_addr1];
			rd2_s2 <= store[q_addr2];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_s2 <= q_cls;
			a1_s2  <= q_addr1;
			a2_s2  <= q_addr2;
			wa_s2  <= q_waddr;
		end
		if (adv && cls_s2.write_en) begin
			fwd_addr_q <= wa_s2;
			fwd_data_q <= {f1, f2};
		end
		if (adv) begin
			result_item.filled_first  <= f1;
			result_item.filled_second <= f2;
			result_item.ref_error     <= cls_s2.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (adv) begin
				valid_s2 <= 1'b0;
			end
			if (adv && cls_s2.write_en) begin
				fwd_valid_q <= 1'b1;
			end
			if (adv) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/umnf_checker.sv =====
// ----------------------------------------------------------------------------
// umnf_checker
// Port-level checks for the missing-node fill block: result hold under
// stall, and the count of transactions in flight against the buffering.
// ----------------------------------------------------------------------------
module umnf_checker import umnf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic edge_valid,
	input logic edge_stall,
	input logic result_valid,
	input logic result_stall,
	input out_t result_item
);

	localparam int OW = $clog2(QUEUE_DEPTH + 4);

	logic          in_acc;
	logic          out_acc;
	logic [OW-1:0] inflight_q;

	assign in_acc  = edge_valid && !edge_stall;
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + OW'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - OW'(1);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result transaction changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> inflight_q != '0)
		else $error("result transaction without an outstanding edge");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OW'(QUEUE_DEPTH + 2))
		else $error("more edges in flight than the block can hold");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		edge_stall |-> inflight_q >= OW'(QUEUE_DEPTH))
		else $error("input stalled with the queue not full");

endmodule

bind undirected_missing_node_fill umnf_checker u_umnf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.edge_valid   (edge_valid),
	.edge_stall   (edge_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);
